// File: rtl/plgs_pkg.sv
// ---------------------------------------------------------------------------
// plgs_pkg
// shared types, constants and lookup tables of the peak limiter
// ---------------------------------------------------------------------------
package plgs_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int TABLE_ADDR_BITS = 8;
  localparam int TAB_SIZE        = 1 << TABLE_ADDR_BITS;
  localparam int GAIN_WIDTH      = 24;
  localparam int POS_W           = $clog2(SAMPLE_WIDTH);
  localparam int NEG_W           = POS_W + 16;
  localparam int MUL_AW          = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH;
  localparam int MUL_BW          = 19;
  localparam int PROD_W          = MUL_AW + MUL_BW;
  localparam int ACC_W           = PROD_W + 1;
  localparam int EXP_W           = 17;
  localparam int N_W             = 22;
  localparam int Q_W             = 6;

  localparam logic [MUL_BW-1:0] DB_PER_OCTAVE = MUL_BW'(394566);
  localparam logic [MUL_BW-1:0] OCTAVE_PER_DB = MUL_BW'(10885);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

  localparam logic signed [15:0] THRESHOLD_RST = -16'sd1536;
  localparam logic [15:0]        ATTACK_RST    = 16'd62604;
  localparam logic [15:0]        RELEASE_RST   = 16'd65506;

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_MUL_LVL, S_MUL_A, S_MUL_B, S_UPD, S_MUL_N, S_GAIN, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LEVEL, OP_MUL_LVL, OP_MUL_A, OP_MUL_B, OP_UPD, OP_MUL_N, OP_GAIN, OP_OUT
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

  typedef logic [15:0]      log2_tab_t [TAB_SIZE];
  typedef logic [EXP_W-1:0] exp2_tab_t [TAB_SIZE];

  function automatic longint unsigned isqrt64(longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v   = val;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/2^A) in Q0.16
  function automatic logic [15:0] log2_entry(int unsigned idx);
    longint unsigned y;
    longint unsigned v;
    y = longint'(TAB_SIZE + idx) << (30 - TABLE_ADDR_BITS);
    v = 0;
    for (int k = 0; k < 17; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        v = (v << 1) | 64'd1;
      end else begin
        v = v << 1;
      end
    end
    return 16'((v + 1) >> 1);
  endfunction

  // 2^(i/2^A) in Q1.16
  function automatic logic [EXP_W-1:0] exp2_entry(int unsigned idx);
    longint unsigned p;
    longint unsigned c;
    p = 64'd1 << 30;
    c = 64'd1 << 31;
    for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
      c = isqrt64(c << 30);
      if (((idx >> (TABLE_ADDR_BITS - k)) & 1) != 0)
        p = (p * c + (64'd1 << 29)) >> 30;
    end
    return EXP_W'((p + (64'd1 << 13)) >> 14);
  endfunction

  function automatic log2_tab_t build_log2();
    log2_tab_t t;
    for (int i = 0; i < TAB_SIZE; i++) t[i] = log2_entry(i);
    return t;
  endfunction

  function automatic exp2_tab_t build_exp2();
    exp2_tab_t t;
    for (int i = 0; i < TAB_SIZE; i++) t[i] = exp2_entry(i);
    return t;
  endfunction

  localparam log2_tab_t LOG2_TAB = build_log2();
  localparam exp2_tab_t EXP2_TAB = build_exp2();

endpackage

// File: rtl/plgs_ctrl.sv
// ---------------------------------------------------------------------------
// plgs_ctrl
// sequencer that steps one item through the shared-multiplier datapath
// ---------------------------------------------------------------------------
module plgs_ctrl import plgs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_LEVEL;
      S_LEVEL:   state_nxt = S_MUL_LVL;
      S_MUL_LVL: state_nxt = S_MUL_A;
      S_MUL_A:   state_nxt = S_MUL_B;
      S_MUL_B:   state_nxt = S_UPD;
      S_UPD:     state_nxt = S_MUL_N;
      S_MUL_N:   state_nxt = S_GAIN;
      S_GAIN:    state_nxt = S_OUT;
      S_OUT:     if (!status.out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_LEVEL:   cmd.op = OP_LEVEL;
      S_MUL_LVL: cmd.op = OP_MUL_LVL;
      S_MUL_A:   cmd.op = OP_MUL_A;
      S_MUL_B:   cmd.op = OP_MUL_B;
      S_UPD:     cmd.op = OP_UPD;
      S_MUL_N:   cmd.op = OP_MUL_N;
      S_GAIN:    cmd.op = OP_GAIN;
      S_OUT:     if (!status.out_stall) cmd.op = OP_OUT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/plgs_datapath.sv
// ---------------------------------------------------------------------------
// plgs_datapath
// level detect, gain smoother and gain multiply around one shared multiplier
// ---------------------------------------------------------------------------
module plgs_datapath import plgs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           cfg_valid,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic signed [GAIN_WIDTH-1:0]   out_gain_db
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int A  = TABLE_ADDR_BITS;

  logic signed [15:0]     thr_r;
  logic [15:0]            att_r, rel_r;
  logic                   neg_r;
  logic [SW-1:0]          m_r;
  logic [NEG_W-1:0]       lvl_r;
  logic [GAIN_WIDTH-1:0]  gc_r;
  logic [15:0]            coef_r;
  logic [ACC_W-1:0]       acc_r;
  logic [GAIN_WIDTH-1:0]  gs_r;
  logic [N_W-1:0]         n_r;
  logic [EXP_W-1:0]       gain_r;
  logic                   out_valid_r;
  logic signed [SW-1:0]   y_r;
  logic signed [GAIN_WIDTH-1:0] gdb_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      att_r <= ATTACK_RST;
      rel_r <= RELEASE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= signed'(cfg_data);
        REG_ATTACK:    att_r <= cfg_data;
        REG_RELEASE:   rel_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // leading one and log2 table lookup
  logic [POS_W-1:0] pos;
  logic [A-1:0]     lidx;
  logic [NEG_W-1:0] lvl_oct;
  always_comb begin
    pos = '0;
    for (int i = 0; i < SW; i++) if (m_r[i]) pos = POS_W'(i);
    if (int'(pos) >= A) lidx = A'(m_r >> (pos - POS_W'(A)));
    else                lidx = A'(m_r << (POS_W'(A) - pos));
    lvl_oct = {POS_W'(SW - 1) - pos, 16'b0} - NEG_W'(LOG2_TAB[lidx]);
  end

  // shared multiplier
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_LVL: begin
        mul_a = MUL_AW'(lvl_r);
        mul_b = DB_PER_OCTAVE;
      end
      OP_MUL_A: begin
        mul_a = MUL_AW'(gs_r);
        mul_b = MUL_BW'(coef_r);
      end
      OP_MUL_B: begin
        mul_a = MUL_AW'(gc_r);
        mul_b = MUL_BW'(18'h10000 - {2'b0, coef_r});
      end
      OP_MUL_N: begin
        mul_a = MUL_AW'(gs_r);
        mul_b = OCTAVE_PER_DB;
      end
      OP_OUT: begin
        mul_a = MUL_AW'(m_r);
        mul_b = MUL_BW'(gain_r);
      end
      default: ;
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  logic [PROD_W-1:0] prod_rnd;
  assign prod_rnd = (prod + PROD_W'(32768)) >> 16;

  // target gain from level and threshold
  logic signed [25:0] neg_thr;
  logic signed [25:0] lvl_mag;
  logic [GAIN_WIDTH-1:0] gc_mag;
  always_comb begin
    neg_thr = -(26'(thr_r) <<< 8);
    lvl_mag = signed'({1'b0, 25'(prod_rnd)});
    if ((m_r != '0) && (prod_rnd < PROD_W'(1 << 25)) && (lvl_mag < neg_thr))
      gc_mag = GAIN_WIDTH'(neg_thr - lvl_mag);
    else
      gc_mag = '0;
  end

  // log2 of gain back to linear
  logic [N_W-1:0]    n_up;
  logic [Q_W-1:0]    q;
  logic [15:0]       f;
  logic [EXP_W-1:0]  g_tab;
  always_comb begin
    n_up  = n_r + N_W'(65535);
    q     = Q_W'(n_up >> 16);
    f     = 16'(({N_W'(q), 16'b0}) - {16'b0, n_r});
    g_tab = EXP2_TAB[f[15 -: A]];
  end

  // output rounding and clamp
  logic [PROD_W-1:0]     ymag;
  logic signed [PROD_W:0] y_full;
  logic signed [SW-1:0]  y_sat;
  localparam logic signed [PROD_W:0] Y_MAX = (PROD_W+1)'((1 << (SW - 1)) - 1);
  localparam logic signed [PROD_W:0] Y_MIN = -(PROD_W+1)'(1 << (SW - 1));
  always_comb begin
    ymag   = prod_rnd;
    y_full = neg_r ? -signed'({1'b0, ymag}) : signed'({1'b0, ymag});
    if (y_full > Y_MAX)      y_sat = SW'(Y_MAX);
    else if (y_full < Y_MIN) y_sat = SW'(Y_MIN);
    else                     y_sat = SW'(y_full);
  end

  assign status.out_stall = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_sample_in[SW-1];
      m_r   <= in_sample_in[SW-1] ? SW'(-in_sample_in) : SW'(in_sample_in);
    end
    case (cmd.op)
      OP_LEVEL:   lvl_r <= lvl_oct;
      OP_MUL_LVL: begin
        gc_r   <= gc_mag;
        coef_r <= (gs_r <= gc_mag) ? att_r : rel_r;
      end
      OP_MUL_A:   acc_r <= ACC_W'(prod);
      OP_MUL_B:   acc_r <= acc_r + ACC_W'(prod);
      OP_MUL_N:   n_r   <= N_W'(prod_rnd);
      OP_GAIN:    gain_r <= (q >= Q_W'(32)) ? '0 : (g_tab >> q);
      // gain held with the sample so the result stays put while it waits
      OP_OUT: begin
        y_r   <= y_sat;
        gdb_r <= -signed'(gs_r);
      end
      default: ;
    endcase
  end

  // smoother state, zero dB after reset
  always_ff @(posedge clk) begin
    if (!rst_n) gs_r <= '0;
    else if (cmd.op == OP_UPD) gs_r <= GAIN_WIDTH'((acc_r + ACC_W'(32768)) >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                 out_valid_r <= 1'b0;
    else if (cmd.op == OP_OUT)  out_valid_r <= 1'b1;
    else if (out_ready)         out_valid_r <= 1'b0;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = y_r;
  assign out_gain_db    = gdb_r;

endmodule

// File: rtl/peak_limiter_gain_smoother_top.sv
// an item runs through the sequencer states, waiting in OUT on a held result;
// only then is a new one taken; the single shared multiplier takes five
// passes per item (level to dB, two smoother terms, dB to octaves, gain apply)
// reset: synchronous active-low rst_n; smoothed gain returns to 0 dB and the
// registers to threshold -6 dB, attack 62604, release 65506
// ---------------------------------------------------------------------------
// peak_limiter_gain_smoother_top
// hard-knee peak limiter with attack/release gain smoothing
// ---------------------------------------------------------------------------
module peak_limiter_gain_smoother_top import plgs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic signed [GAIN_WIDTH-1:0]   out_gain_db,
  // register writes, always taken
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [15:0]                    cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // sequencer: one item at a time, waits in its last step on a full output
  plgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config, level table, smoother state, output register
  plgs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample_in   (in_sample_in),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_gain_db    (out_gain_db)
  );

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item");

  // applied gain never boosts
  a_gain_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_db[GAIN_WIDTH-1] || out_gain_db == '0))
    else $error("positive gain reported");

  // a fresh result only appears as the sequencer finishes, never from idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

// File: tb/peak_limiter_gain_smoother_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// peak_limiter_gain_smoother_checker
// watches the sample, result and register channels, predicts every result
// of the limiter from its own fixed-point model and compares field by field
// ---------------------------------------------------------------------------
module peak_limiter_gain_smoother_checker import plgs_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic signed [GAIN_WIDTH-1:0]   out_gain_db,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count
);

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [GAIN_WIDTH-1:0]   gain;
  } limited_t;

  limited_t        limited_q[$];
  int unsigned     log_frac[TAB_SIZE];
  int unsigned     pow_frac[TAB_SIZE];
  logic signed [15:0] thr_q88;
  logic [15:0]     atk_coef;
  logic [15:0]     rel_coef;
  longint          smooth_db;

  function automatic longint unsigned floor_root(longint unsigned val);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = val;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/256), squaring method, Q0.16
  function automatic int unsigned calc_log_frac(int unsigned i);
    longint unsigned y;
    longint unsigned v;
    y = longint'(TAB_SIZE + i) << (30 - TABLE_ADDR_BITS);
    v = 0;
    for (int k = 0; k < 17; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        v = (v << 1) | 1;
      end else begin
        v = v << 1;
      end
    end
    return int'((v + 1) >> 1);
  endfunction

  // 2^(i/256) as product of repeated roots of two, Q1.16
  function automatic int unsigned calc_pow_frac(int unsigned i);
    longint unsigned p;
    longint unsigned c;
    p = 64'd1 << 30;
    c = 64'd1 << 31;
    for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
      c = floor_root(c << 30);
      if (((i >> (TABLE_ADDR_BITS - k)) & 1) != 0)
        p = (p * c + (64'd1 << 29)) >> 30;
    end
    return int'((p + (64'd1 << 13)) >> 14);
  endfunction

  // magnitude of the level below full scale, dB in Q8.16
  function automatic longint level_below_fs(longint m);
    int     p;
    longint idx;
    longint lg;
    longint neg;
    p = 31;
    while (p > 0 && m[p] == 1'b0) p--;
    if (p >= TABLE_ADDR_BITS) idx = (m >> (p - TABLE_ADDR_BITS)) & (TAB_SIZE - 1);
    else                      idx = (m << (TABLE_ADDR_BITS - p)) & (TAB_SIZE - 1);
    lg  = longint'(p - (SAMPLE_WIDTH - 1)) * 65536 + longint'(log_frac[idx]);
    neg = (lg < 0) ? -lg : 0;
    return (neg * 394566 + 32768) >> 16;
  endfunction

  // advances the smoothed gain and returns the limited sample with that gain
  function automatic limited_t limit_sample(logic signed [SAMPLE_WIDTH-1:0] s);
    limited_t r;
    longint x, m, gc, thr, lvl, a, sum, n, q, f, g, ym, y, lim;
    x   = longint'(s);
    m   = (x < 0) ? -x : x;
    gc  = 0;
    thr = longint'(thr_q88) * 256;
    if (m != 0) begin
      lvl = -level_below_fs(m);
      if (lvl > thr) gc = thr - lvl;
    end
    a         = (smooth_db >= gc) ? longint'(atk_coef) : longint'(rel_coef);
    sum       = a * (-smooth_db) + (65536 - a) * (-gc);
    smooth_db = -((sum + 32768) >> 16);
    n = ((-smooth_db) * 10885 + 32768) >> 16;
    q = (n + 65535) >> 16;
    f = q * 65536 - n;
    g = longint'(pow_frac[f >> (16 - TABLE_ADDR_BITS)]);
    g = (q >= 32) ? 0 : (g >> q);
    ym  = (m * g + 32768) >> 16;
    y   = (x < 0) ? -ym : ym;
    lim = longint'(1) << (SAMPLE_WIDTH - 1);
    if (y > lim - 1) y = lim - 1;
    if (y < -lim) y = -lim;
    r.sample = y[SAMPLE_WIDTH-1:0];
    r.gain   = smooth_db[GAIN_WIDTH-1:0];
    return r;
  endfunction

  initial begin
    for (int i = 0; i < TAB_SIZE; i++) begin
      log_frac[i] = calc_log_frac(i);
      pow_frac[i] = calc_pow_frac(i);
    end
    fail_count    = 0;
    checked_count = 0;
    thr_q88   = THRESHOLD_RST;
    atk_coef  = ATTACK_RST;
    rel_coef  = RELEASE_RST;
    smooth_db = 0;
  end

  assign pending_count = limited_q.size();

  always @(posedge clk) begin
    limited_t exp_r;
    if (!rst_n) begin
      thr_q88   = THRESHOLD_RST;
      atk_coef  = ATTACK_RST;
      rel_coef  = RELEASE_RST;
      smooth_db = 0;
      limited_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_q88  = cfg_data;
          REG_ATTACK:    atk_coef = cfg_data;
          REG_RELEASE:   rel_coef = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) limited_q.push_back(limit_sample(in_sample_in));
      if (out_valid && out_ready) begin
        checked_count++;
        if (limited_q.size() == 0) begin
          $display("%0t: unexpected result sample %0d gain %0d", $time,
                   out_sample_out, out_gain_db);
          fail_count++;
        end else begin
          exp_r = limited_q.pop_front();
          if (out_sample_out !== exp_r.sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     exp_r.sample, out_sample_out);
            fail_count++;
          end
          if (out_gain_db !== exp_r.gain) begin
            $display("%0t: gain_db expected %0d actual %0d", $time,
                     exp_r.gain, out_gain_db);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/peak_limiter_gain_smoother_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// peak_limiter_gain_smoother_top_tb
// drives samples and register writes into the limiter under random idling on
// both channels; the checker beside the block predicts and compares results
// ---------------------------------------------------------------------------
module peak_limiter_gain_smoother_top_tb import plgs_pkg::*;;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_in;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_out;
  logic signed [GAIN_WIDTH-1:0]   out_gain_db;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [15:0]                    cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;
  int samples_sent;
  int cfg_writes;
  bit no_idle;      // phases with back-to-back traffic on both sides
  int stall_left;

  peak_limiter_gain_smoother_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_gain_db    (out_gain_db),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  peak_limiter_gain_smoother_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_gain_db    (out_gain_db),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // result side back-pressure, same gap profile as the sender
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // valid stays high from one item to the next when there is no gap,
  // so it is only lowered at the start of a gap
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // registers change only with nothing in flight in the block
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] atk,
                          input logic [15:0] rel);
    drain();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
  endtask

  // loud and quiet samples mixed so that both attack and release get exercised
  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    logic signed [SAMPLE_WIDTH-1:0] s;
    s = SAMPLE_WIDTH'($urandom());
    if ($urandom_range(0, 3) != 0) s = s >>> $urandom_range(0, SAMPLE_WIDTH - 1);
    return s;
  endfunction

  task automatic random_samples(input int count);
    for (int i = 0; i < count; i++) send_sample(rand_sample());
  endtask

  initial begin
    logic signed [SAMPLE_WIDTH-1:0] directed[$];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    no_idle      = 1'b0;
    samples_sent = 0;
    cfg_writes   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero, unit steps, full scale both signs, loud then silence
    directed = '{24'sd0, 24'sd1, -24'sd1, 24'sh7fffff, -24'sh800000, 24'sh7fffff,
                 -24'sh800000, 24'sd0, 24'sd0, 24'sd256, -24'sd255, 24'sd4096,
                 -24'sd100000, 24'sh400000, 24'sh5a5a5a, -24'sh2a5a5b, 24'sd3,
                 24'sd0, 24'sh7fffff, 24'sd1};
    foreach (directed[i]) send_sample(directed[i]);

    // threshold at 0 dB, instant coefficients, and the unused index
    set_regs(16'h0000, 16'd0, 16'd0);
    write_reg(2'd3, 16'hffff);
    send_sample(-24'sh800000);
    send_sample(24'sh7fffff);
    send_sample(24'sd0);
    random_samples(100);

    // lowest threshold the field holds, slowest coefficients
    set_regs(16'h8000, 16'hffff, 16'hffff);
    random_samples(110);

    // stated lower threshold, instant attack, slow release, no idling
    no_idle = 1'b1;
    set_regs(-16'sd24576, 16'd0, 16'hffff);
    random_samples(110);
    no_idle = 1'b0;

    // highest positive threshold, slow attack, instant release
    set_regs(16'h7fff, 16'hffff, 16'd0);
    random_samples(80);

    set_regs(-16'sd768, 16'd30000, 16'd60000);
    random_samples(110);

    // random settings in the stated ranges
    for (int ph = 0; ph < 3; ph++) begin
      set_regs(16'(-$urandom_range(0, 24576)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
      random_samples(80);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d samples sent, %0d results checked, %0d register writes",
             samples_sent, checked_count, cfg_writes);
    $display("tb: thresholds from -128 dB to +128 dB, coefficients at both ends");
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: peak_limiter_gain_smoother_top.f
rtl/plgs_pkg.sv
rtl/plgs_ctrl.sv
rtl/plgs_datapath.sv
rtl/peak_limiter_gain_smoother_top.sv
tb/peak_limiter_gain_smoother_checker.sv
tb/peak_limiter_gain_smoother_top_tb.sv
